@@ rtl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, widths and constants of the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int GRAD_W      = 11;
    localparam int SUM_W       = GRAD_W + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] WIDTH_MIN    = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MIN   = CFG_W'(3);
    localparam logic [PIX_W-1:0] MAG_MAX      = {PIX_W{1'b1}};

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // one column entering the window: two stored rows plus the live pixel
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
    } t_column;

    // one line store entry holds both older rows of a column
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
    } t_line_pair;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_result;

    function automatic logic [GRAD_W-1:0] abs_grad(input logic signed [GRAD_W-1:0] v);
        return v[GRAD_W-1] ? GRAD_W'(-v) : v;
    endfunction

endpackage

@@ rtl/sem_line_store.sv @@
// ----------------------------------------------------------------------------
// sem_line_store
// Line buffer RAM: one entry per column holding the two previous rows.
// One read port with registered data, one write port.
// ----------------------------------------------------------------------------
module sem_line_store (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [sem_pkg::COL_W-1:0]   i_rd_addr,
    output sem_pkg::t_line_pair         o_rd_data,
    input  logic                        i_wr_en,
    input  logic [sem_pkg::COL_W-1:0]   i_wr_addr,
    input  sem_pkg::t_line_pair         i_wr_data
);

    sem_pkg::t_line_pair r_mem [sem_pkg::MAX_WIDTH];
    sem_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sem_window.sv @@
// ----------------------------------------------------------------------------
// sem_window
// 3x3 pixel window and Sobel kernels. Each beat shifts a new column in and
// registers the two gradients of the resulting window.
// ----------------------------------------------------------------------------
module sem_window (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  sem_pkg::t_column                     i_col,
    output logic signed [sem_pkg::GRAD_W-1:0]    o_gx,
    output logic signed [sem_pkg::GRAD_W-1:0]    o_gy
);

    logic [sem_pkg::PIX_W-1:0]          r_win [9];
    logic [sem_pkg::PIX_W-1:0]          n_win [9];
    logic signed [sem_pkg::GRAD_W-1:0]  r_gx;
    logic signed [sem_pkg::GRAD_W-1:0]  r_gy;
    logic signed [sem_pkg::GRAD_W-1:0]  n_gx;
    logic signed [sem_pkg::GRAD_W-1:0]  n_gy;
    logic signed [sem_pkg::GRAD_W-1:0]  p [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3 + 0] = r_win[k*3 + 1];
            n_win[k*3 + 1] = r_win[k*3 + 2];
        end
        n_win[2] = i_col.up;
        n_win[5] = i_col.mid;
        n_win[8] = i_col.px;
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p[k] = $signed({{(sem_pkg::GRAD_W - sem_pkg::PIX_W){1'b0}}, n_win[k]});
        end
        n_gx = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
        n_gy = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_valid) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
        end
    end

    assign o_gx = r_gx;
    assign o_gy = r_gy;

endmodule

@@ rtl/sem_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sem_out_fifo
// Small result queue at the output. Its head drives the output channel,
// and its fill level feeds the input-side stall.
// ----------------------------------------------------------------------------
module sem_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  sem_pkg::t_result                  i_entry,
    output logic                              o_valid,
    output sem_pkg::t_result                  o_entry,
    input  logic                              i_stall,
    output logic [sem_pkg::FIFO_CNT_W-1:0]    o_count
);

    sem_pkg::t_result                   r_mem [sem_pkg::FIFO_DEPTH];
    logic [sem_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [sem_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [sem_pkg::FIFO_CNT_W-1:0]     r_count;
    logic [sem_pkg::FIFO_CNT_W-1:0]     n_count;
    logic                               w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // never push into a full queue unless a beat leaves at the same edge
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == sem_pkg::FIFO_CNT_W'(sem_pkg::FIFO_DEPTH)) && !w_pop |-> !i_push)
        else $error("result queue overflow");

    // pointers and count stay consistent
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == sem_pkg::FIFO_CNT_W'(sem_pkg::FIFO_DEPTH))
        || (r_count[sem_pkg::FIFO_PTR_W-1:0] == (r_wr_ptr - r_rd_ptr)))
        else $error("result queue pointers disagree with count");

endmodule

@@ rtl/sobel_edge_magnitude_core.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// Streaming 3x3 Sobel edge detector, L1 magnitude saturated at 255.
//
// Input channel: i_valid / o_stall / i_pixel, grey pixels in raster order.
// Output channel: o_valid / i_stall / o_edge_magnitude, o_center_row,
// o_center_col, o_frame_last. One result per interior pixel; border pixels
// give none. o_frame_last marks the last interior pixel of the frame.
// Frame size comes from the APB registers image_width (0x0) and
// image_height (0x4); change them only while the core is idle.
// A result is registered in stage 1, in the gradient registers and in the queue.
// Throughput: one pixel per clock while o_stall is low, set by the single line store
// RAM (one read at accept, write-back in the cycle after).
// A four-entry result queue decouples the output: o_stall rises only when
// queued plus in-flight beats would fill it, so a stalled receiver holds
// results and backs up the input after a few beats.
// Reset clears the counters, window and queue and restores 640x480; the
// line store content is undefined until the first two rows are written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sem_pkg::PIX_W-1:0]     o_edge_magnitude,
    output logic [sem_pkg::ROW_W-1:0]     o_center_row,
    output logic [sem_pkg::COL_W-1:0]     o_center_col,
    output logic                          o_frame_last,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [sem_pkg::CFG_W-1:0]      r_image_width;
    logic [sem_pkg::CFG_W-1:0]      r_image_height;
    sem_pkg::t_reg_idx              w_reg_idx;
    logic                           w_cfg_wr;

    logic [sem_pkg::COL_W-1:0]      r_col_cnt;
    logic [sem_pkg::ROW_W-1:0]      r_row_cnt;
    logic [sem_pkg::COL_W-1:0]      n_col_cnt;
    logic [sem_pkg::ROW_W-1:0]      n_row_cnt;
    logic [sem_pkg::CFG_W-1:0]      w_width_eff;
    logic [sem_pkg::CFG_W-1:0]      w_height_eff;
    logic                           w_line_end;
    logic                           w_frame_end;
    logic                           w_accept;
    sem_pkg::t_meta                 w_s0_meta;

    logic                           r_s1_valid;
    sem_pkg::t_meta                 r_s1_meta;
    logic [sem_pkg::COL_W-1:0]      r_s1_addr;
    logic [sem_pkg::PIX_W-1:0]      r_s1_px;

    logic                           r_s2_valid;
    sem_pkg::t_meta                 r_s2_meta;

    sem_pkg::t_line_pair            w_rd_data;
    sem_pkg::t_line_pair            w_wr_data;
    sem_pkg::t_column               w_column;
    logic signed [sem_pkg::GRAD_W-1:0] w_gx;
    logic signed [sem_pkg::GRAD_W-1:0] w_gy;
    logic [sem_pkg::SUM_W-1:0]      w_mag_sum;
    sem_pkg::t_result               w_result;
    logic                           w_push;
    sem_pkg::t_result               w_head;
    logic [sem_pkg::FIFO_CNT_W-1:0] w_fifo_count;
    logic [sem_pkg::FIFO_CNT_W:0]   w_occupancy;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = sem_pkg::t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sem_pkg::WIDTH_RESET;
            r_image_height <= sem_pkg::HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                sem_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[sem_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            sem_pkg::REG_IMAGE_WIDTH:  prdata = {{(32 - sem_pkg::CFG_W){1'b0}}, r_image_width};
            sem_pkg::REG_IMAGE_HEIGHT: prdata = {{(32 - sem_pkg::CFG_W){1'b0}}, r_image_height};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- stage 0: accept, raster counters ----------------
    assign w_occupancy = {1'b0, w_fifo_count}
                       + (sem_pkg::FIFO_CNT_W + 1)'(r_s1_valid)
                       + (sem_pkg::FIFO_CNT_W + 1)'(r_s2_valid);
    assign o_stall  = (w_occupancy >= (sem_pkg::FIFO_CNT_W + 1)'(sem_pkg::FIFO_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (r_image_width < sem_pkg::WIDTH_MIN) begin
            w_width_eff = sem_pkg::WIDTH_MIN;
        end else if (r_image_width > sem_pkg::WIDTH_MAX) begin
            w_width_eff = sem_pkg::WIDTH_MAX;
        end else begin
            w_width_eff = r_image_width;
        end
        if (r_image_height < sem_pkg::HEIGHT_MIN) begin
            w_height_eff = sem_pkg::HEIGHT_MIN;
        end else begin
            w_height_eff = r_image_height;
        end
    end

    assign w_line_end  = ({1'b0, r_col_cnt} >= (w_width_eff - 1'b1));
    assign w_frame_end = (r_row_cnt >= (w_height_eff - 1'b1));

    always_comb begin
        w_s0_meta.emit = (r_row_cnt >= sem_pkg::ROW_W'(2))
                      && (r_col_cnt >= sem_pkg::COL_W'(2));
        w_s0_meta.row  = r_row_cnt - 1'b1;
        w_s0_meta.col  = r_col_cnt - 1'b1;
        w_s0_meta.last = w_line_end && w_frame_end;
    end

    always_comb begin
        n_col_cnt = r_col_cnt + 1'b1;
        n_row_cnt = r_row_cnt;
        if (w_line_end) begin
            n_col_cnt = '0;
            n_row_cnt = w_frame_end ? '0 : r_row_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // ---------------- stage 1: line store data back, write-back ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_meta <= w_s0_meta;
            r_s1_addr <= r_col_cnt;
            r_s1_px   <= i_pixel;
        end
        if (r_s1_valid) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // the column moves up one row: middle becomes upper, pixel becomes middle
    assign w_wr_data.up  = w_rd_data.mid;
    assign w_wr_data.mid = r_s1_px;

    sem_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data)
    );

    assign w_column.up  = w_rd_data.up;
    assign w_column.mid = w_rd_data.mid;
    assign w_column.px  = r_s1_px;

    sem_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_col   (w_column),
        .o_gx    (w_gx),
        .o_gy    (w_gy)
    );

    // ---------------- stage 2: magnitude, into result queue ----------------
    assign w_mag_sum = {1'b0, sem_pkg::abs_grad(w_gx)} + {1'b0, sem_pkg::abs_grad(w_gy)};

    always_comb begin
        w_result.mag  = (w_mag_sum > sem_pkg::SUM_W'(sem_pkg::MAG_MAX))
                      ? sem_pkg::MAG_MAX : w_mag_sum[sem_pkg::PIX_W-1:0];
        w_result.row  = r_s2_meta.row;
        w_result.col  = r_s2_meta.col;
        w_result.last = r_s2_meta.last;
    end

    assign w_push = r_s2_valid && r_s2_meta.emit;

    sem_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_result),
        .o_valid (o_valid),
        .o_entry (w_head),
        .i_stall (i_stall),
        .o_count (w_fifo_count)
    );

    assign o_edge_magnitude = w_head.mag;
    assign o_center_row     = w_head.row;
    assign o_center_col     = w_head.col;
    assign o_frame_last     = w_head.last;

    // read and pending write-back of back-to-back beats never hit one column
    a_no_raw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_s1_valid |-> (r_col_cnt != r_s1_addr))
        else $error("line store read collides with pending write-back");

    // in-flight beats plus queued results never exceed queue capacity
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occupancy <= (sem_pkg::FIFO_CNT_W + 1)'(sem_pkg::FIFO_DEPTH))
        else $error("result credit accounting broken");

    // a pushed result always sits on an interior pixel
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_s2_meta.row != '0) && (r_s2_meta.col != '0))
        else $error("result emitted for a border pixel");

endmodule
